// ----- hw/rtl/crlz_pkg.sv -----
// shared types, constants and preset dictionary table for the compressed rtf decompressor
package crlz_pkg;

    localparam int DICT_DEPTH    = 4096;
    localparam int DICT_AW       = 12;
    localparam int PRESET_LENGTH = 207;
    localparam int OVF_SLACK     = 20;

    localparam logic [1:0] ST_DATA     = 2'd0;
    localparam logic [1:0] ST_END_MARK = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_NO_END   = 2'd3;

    localparam logic [PRESET_LENGTH*8-1:0] PRESET_TEXT = {
        "{\\rtf1\\ansi\\mac\\deff0\\deftab720{\\fonttbl;}",
        "{\\f0\\fnil \\froman \\fswiss \\fmodern \\fscrip",
        "t \\fdecor MS Sans SerifSymbolArialTimes Ne",
        "w RomanCourier{\\colortbl\\red0\\green0\\blue0",
        "\015\012\\par \\pard\\plain\\f0\\fs20\\b\\i\\u\\tab",
        "\\tx"
    };

    typedef struct packed {
        logic [7:0] in_byte;
        logic       new_stream;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        has_byte;
        logic [1:0]  status;
        logic        run_last;
        logic [31:0] total_out;
    } t_out;

    typedef struct packed {
        logic               we;
        logic [DICT_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
        logic               rd_en;
        logic [DICT_AW-1:0] rd_addr;
    } t_ram_req;

    // dictionary content of an entry not yet written in this stream
    function automatic logic [7:0] preset_byte(input logic [DICT_AW-1:0] addr);
        logic [7:0] b;
        b = 8'h00;
        if (addr < DICT_AW'(PRESET_LENGTH)) begin
            b = PRESET_TEXT[(PRESET_LENGTH - 1 - int'(addr))*8 +: 8];
        end
        return b;
    endfunction

endpackage

// ----- hw/rtl/crlz_dict_ram.sv -----
// ring dictionary memory: one write port, one registered read port
module crlz_dict_ram
    import crlz_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    output logic [7:0] o_rd_data
);

    logic [7:0] r_mem [DICT_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/crlz_core.sv -----
// decode sequencer: control flags, literals, references and byte-by-byte copy
module crlz_core
    import crlz_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_raw_size,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,
    input  logic        i_slot_free,
    output logic        o_res_valid,
    output t_out        o_res,
    output t_ram_req    o_ram_req,
    input  logic [7:0]  i_ram_data
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_COPY   = 2'd2;

    localparam logic [1:0] PH_CONTROL = 2'd0;
    localparam logic [1:0] PH_ITEM    = 2'd1;
    localparam logic [1:0] PH_REF_LOW = 2'd2;

    localparam logic SRC_MEM = 1'b0;
    localparam logic SRC_ALT = 1'b1;

    logic [1:0]         r_state, n_state;
    logic [7:0]         r_byte, n_byte;
    logic               r_last, n_last;
    logic [DICT_AW-1:0] r_wp, n_wp;
    logic [1:0]         r_phase, n_phase;
    logic [7:0]         r_flags, n_flags;
    logic [2:0]         r_idx, n_idx;
    logic [7:0]         r_ref_high, n_ref_high;
    logic [31:0]        r_count, n_count;
    logic               r_done, n_done;
    logic [DICT_AW:0]   r_fill, n_fill;
    logic [DICT_AW-1:0] r_rd_addr, n_rd_addr;
    logic [4:0]         r_remain, n_remain;
    logic               r_src, n_src;
    logic [7:0]         r_alt, n_alt;

    logic               w_ovf;
    logic [31:0]        w_count_inc;
    logic [DICT_AW-1:0] w_wp_inc;
    logic [2:0]         w_idx_adv;
    logic [1:0]         w_phase_adv;
    logic [15:0]        w_ref_word;
    logic [DICT_AW-1:0] w_offset;
    logic [7:0]         w_copy_byte;
    logic [DICT_AW-1:0] w_rel;
    logic               w_written;
    logic               w_we;
    logic [7:0]         w_wr_data;
    logic               w_rd_en;
    logic [DICT_AW-1:0] w_rd_addr;
    logic               w_res_valid;
    t_out               w_res;

    function automatic t_out mk_res(input logic [7:0] b, input logic has,
                                    input logic [1:0] st, input logic [31:0] cnt);
        t_out r;
        r.out_byte  = b;
        r.has_byte  = has;
        r.status    = st;
        r.run_last  = 1'b1;
        r.total_out = cnt;
        return r;
    endfunction

    assign w_ovf       = {1'b0, r_count} > ({1'b0, i_raw_size} + 33'(OVF_SLACK));
    assign w_count_inc = r_count + 32'd1;
    assign w_wp_inc    = r_wp + DICT_AW'(1);
    assign w_idx_adv   = (r_idx == 3'd7) ? 3'd0 : r_idx + 3'd1;
    assign w_phase_adv = (r_idx == 3'd7) ? PH_CONTROL : r_phase;
    assign w_ref_word  = {r_ref_high, r_byte};
    assign w_offset    = w_ref_word[15:4];
    assign w_copy_byte = (r_src == SRC_MEM) ? i_ram_data : r_alt;
    assign o_in_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_byte     = r_byte;
        n_last     = r_last;
        n_wp       = r_wp;
        n_phase    = r_phase;
        n_flags    = r_flags;
        n_idx      = r_idx;
        n_ref_high = r_ref_high;
        n_count    = r_count;
        n_done     = r_done;
        n_fill     = r_fill;
        n_rd_addr  = r_rd_addr;
        n_remain   = r_remain;
        n_src      = r_src;
        n_alt      = r_alt;
        w_we        = 1'b0;
        w_wr_data   = w_copy_byte;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_rd_addr;
        w_res_valid = 1'b0;
        w_res       = mk_res(8'h00, 1'b0, ST_DATA, r_count);
        w_rel       = '0;
        w_written   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_byte  = i_in.in_byte;
                    n_last  = i_in.last_byte;
                    n_state = S_DECODE;
                    if (i_in.new_stream) begin
                        n_wp       = DICT_AW'(PRESET_LENGTH);
                        n_phase    = PH_CONTROL;
                        n_flags    = 8'h00;
                        n_idx      = 3'd0;
                        n_ref_high = 8'h00;
                        n_count    = 32'd0;
                        n_done     = 1'b0;
                        n_fill     = '0;
                    end
                end
            end
            S_DECODE: begin
                if (r_done) begin
                    n_state = S_IDLE;
                end else begin
                    case (r_phase)
                        PH_CONTROL: begin
                            if (!r_last || i_slot_free) begin
                                n_flags = r_byte;
                                n_idx   = 3'd0;
                                n_phase = PH_ITEM;
                                n_state = S_IDLE;
                                if (r_last) begin
                                    w_res_valid = 1'b1;
                                    w_res  = mk_res(8'h00, 1'b0, ST_NO_END, r_count);
                                    n_done = 1'b1;
                                end
                            end
                        end
                        PH_ITEM: begin
                            if (r_flags[r_idx]) begin
                                if (!r_last || i_slot_free) begin
                                    n_ref_high = r_byte;
                                    n_phase    = PH_REF_LOW;
                                    n_state    = S_IDLE;
                                    if (r_last) begin
                                        w_res_valid = 1'b1;
                                        w_res  = mk_res(8'h00, 1'b0, ST_NO_END, r_count);
                                        n_done = 1'b1;
                                    end
                                end
                            end else if (i_slot_free) begin
                                // literal byte
                                w_res_valid = 1'b1;
                                n_idx   = w_idx_adv;
                                n_phase = w_phase_adv;
                                n_state = S_IDLE;
                                if (w_ovf) begin
                                    w_res  = mk_res(8'h00, 1'b0, ST_OVERFLOW, r_count);
                                    n_done = 1'b1;
                                end else begin
                                    w_we      = 1'b1;
                                    w_wr_data = r_byte;
                                    n_wp      = w_wp_inc;
                                    n_count   = w_count_inc;
                                    w_res = mk_res(r_byte, 1'b1,
                                                   r_last ? ST_NO_END : ST_DATA,
                                                   w_count_inc);
                                    n_done = r_last;
                                end
                            end
                        end
                        PH_REF_LOW: begin
                            if (w_offset == r_wp) begin
                                if (i_slot_free) begin
                                    w_res_valid = 1'b1;
                                    w_res   = mk_res(8'h00, 1'b0, ST_END_MARK, r_count);
                                    n_done  = 1'b1;
                                    n_phase = PH_ITEM;
                                    n_state = S_IDLE;
                                end
                            end else begin
                                // first read of the copy, remaining count excludes it
                                n_phase   = PH_ITEM;
                                w_rd_en   = 1'b1;
                                w_rd_addr = w_offset;
                                n_rd_addr = w_offset + DICT_AW'(1);
                                n_remain  = {1'b0, r_byte[3:0]} + 5'd1;
                                n_state   = S_COPY;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_COPY: begin
                if (i_slot_free) begin
                    w_res_valid = 1'b1;
                    if (w_ovf) begin
                        w_res   = mk_res(8'h00, 1'b0, ST_OVERFLOW, r_count);
                        n_done  = 1'b1;
                        n_idx   = w_idx_adv;
                        n_phase = w_phase_adv;
                        n_state = S_IDLE;
                    end else begin
                        w_we    = 1'b1;
                        n_wp    = w_wp_inc;
                        n_count = w_count_inc;
                        if (r_remain == 5'd0) begin
                            w_res   = mk_res(w_copy_byte, 1'b1,
                                             r_last ? ST_NO_END : ST_DATA, w_count_inc);
                            n_done  = r_last;
                            n_idx   = w_idx_adv;
                            n_phase = w_phase_adv;
                            n_state = S_IDLE;
                        end else begin
                            w_res          = mk_res(w_copy_byte, 1'b1, ST_DATA, w_count_inc);
                            w_res.run_last = 1'b0;
                            n_remain  = r_remain - 5'd1;
                            w_rd_en   = 1'b1;
                            w_rd_addr = r_rd_addr;
                            n_rd_addr = r_rd_addr + DICT_AW'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_we && !r_fill[DICT_AW]) begin
            n_fill = r_fill + (DICT_AW+1)'(1);
        end

        // pick the byte source for the read just issued
        if (w_rd_en) begin
            w_rel     = w_rd_addr - DICT_AW'(PRESET_LENGTH);
            w_written = r_fill[DICT_AW] || (w_rel < r_fill[DICT_AW-1:0]);
            if (w_we && (w_rd_addr == r_wp)) begin
                n_src = SRC_ALT;
                n_alt = w_wr_data;
            end else if (w_written) begin
                n_src = SRC_MEM;
                n_alt = w_wr_data;
            end else begin
                n_src = SRC_ALT;
                n_alt = preset_byte(w_rd_addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wp       <= DICT_AW'(PRESET_LENGTH);
            r_phase    <= PH_CONTROL;
            r_flags    <= 8'h00;
            r_idx      <= 3'd0;
            r_ref_high <= 8'h00;
            r_count    <= 32'd0;
            r_done     <= 1'b0;
            r_fill     <= '0;
            r_remain   <= 5'd0;
        end else begin
            r_state    <= n_state;
            r_wp       <= n_wp;
            r_phase    <= n_phase;
            r_flags    <= n_flags;
            r_idx      <= n_idx;
            r_ref_high <= n_ref_high;
            r_count    <= n_count;
            r_done     <= n_done;
            r_fill     <= n_fill;
            r_remain   <= n_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte    <= n_byte;
        r_last    <= n_last;
        r_rd_addr <= n_rd_addr;
        r_src     <= n_src;
        r_alt     <= n_alt;
    end

    assign o_res_valid = w_res_valid;
    assign o_res       = w_res;

    assign o_ram_req.we      = w_we;
    assign o_ram_req.wr_addr = r_wp;
    assign o_ram_req.wr_data = w_wr_data;
    assign o_ram_req.rd_en   = w_rd_en;
    assign o_ram_req.rd_addr = w_rd_addr;

    a_res_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_slot_free)
        else $error("result produced without a free output slot");

    a_write_is_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (o_res_valid && o_res.has_byte && (o_res.total_out == w_count_inc)))
        else $error("dictionary write without a matching emitted byte");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (DICT_AW+1)'(DICT_DEPTH))
        else $error("fill count beyond dictionary depth");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.run_last) |=> (r_state == S_IDLE))
        else $error("sequencer busy after final result of an item");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!o_res_valid && !w_we))
        else $error("activity while idle");

endmodule

// ----- hw/rtl/compressed_rtf_lz_decompressor.sv -----
// top level: configuration register, output register, sequencer and dictionary memory
//
// Compressed RTF (LZFu) body decompressor. Body bytes of the stream, header
// stripped, enter one per transaction on the input channel (i_in_valid /
// o_in_ready, payload t_in). Set new_stream on the first byte of each stream
// and last_byte on the final one. Results leave on the output channel
// (o_out_valid / i_out_ready, payload t_out); run_last marks the final result
// of each input byte. The user writes raw_size on the config channel while
// idle; the block itself does not enforce it.
// Sequence: a byte taken while idle is registered, then decoded; a result
// waits for a free output slot and is registered in the output register.
// A back reference then copies one output byte per cycle while the slot is
// free, set by the single dictionary read and write per byte. A stalled
// receiver holds the output register and the copy waits in place.
// Reset clears the control state and raw_size; entries of the 4096-byte
// dictionary not yet written in the current stream read from the preset
// table through a fill count, so neither reset nor new_stream needs a
// clearing pass.
module compressed_rtf_lz_decompressor
    import crlz_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_raw_size;
    logic        r_out_valid;
    t_out        r_out;
    logic        w_slot_free;
    logic        w_res_valid;
    t_out        w_res;
    t_ram_req    w_ram_req;
    logic [7:0]  w_ram_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_size <= 32'd0;
        end else if (i_cfg_valid) begin
            r_raw_size <= i_cfg_data;
        end
    end

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    crlz_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_raw_size  (r_raw_size),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_slot_free (w_slot_free),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_ram_req   (w_ram_req),
        .i_ram_data  (w_ram_data)
    );

    crlz_dict_ram u_dict (
        .i_clk     (i_clk),
        .i_req     (w_ram_req),
        .o_rd_data (w_ram_data)
    );

endmodule

// ----- sim/compressed_rtf_lz_decompressor_test.sv -----
// self-checking testbench for the compressed rtf (lzfu) body decompressor
`timescale 1ns / 100ps

module compressed_rtf_lz_decompressor_test;
    import crlz_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 25;

    typedef enum logic [1:0] {
        WANT_CONTROL,
        WANT_ITEM,
        WANT_REF_LOW
    } t_dec_phase;

    class lzfu_board;
        logic [7:0]  dict [DICT_DEPTH];
        logic [11:0] wp;
        t_dec_phase  phase;
        logic [7:0]  flags;
        logic [2:0]  fidx;
        logic [7:0]  ref_hi;
        logic [31:0] count;
        bit          done;
        logic [31:0] raw_size;
        t_out        step_out [18];
        int          nstep;
        t_out        output_due [$];
        int          errors;

        function new();
            restart();
            raw_size = 32'd0;
            errors   = 0;
        endfunction

        function void restart();
            for (int i = 0; i < DICT_DEPTH; i++) begin
                dict[i] = (i < PRESET_LENGTH) ? PRESET_TEXT[(PRESET_LENGTH - 1 - i)*8 +: 8]
                                              : 8'h00;
            end
            wp     = 12'(PRESET_LENGTH);
            phase  = WANT_CONTROL;
            flags  = 8'h00;
            fidx   = 3'd0;
            ref_hi = 8'h00;
            count  = 32'd0;
            done   = 1'b0;
        endfunction

        function void put(logic [7:0] b, logic has, logic [1:0] st);
            t_out r;
            r.out_byte  = b;
            r.has_byte  = has;
            r.status    = st;
            r.run_last  = 1'b0;
            r.total_out = count;
            step_out[nstep] = r;
            nstep++;
        endfunction

        function bit emit(logic [7:0] b);
            if ({1'b0, count} > {1'b0, raw_size} + 33'd20) begin
                put(8'h00, 1'b0, ST_OVERFLOW);
                done = 1'b1;
                return 1'b0;
            end
            dict[wp] = b;
            wp       = wp + 12'd1;
            count    = count + 32'd1;
            put(b, 1'b1, ST_DATA);
            return 1'b1;
        endfunction

        function void advance_flag();
            if (fidx == 3'd7) begin
                fidx  = 3'd0;
                phase = WANT_CONTROL;
            end else begin
                fidx = fidx + 3'd1;
            end
        endfunction

        function void decode_byte(t_in it);
            logic [15:0] word;
            logic [11:0] offset;
            logic [11:0] rd;
            int          len;
            nstep = 0;
            if (it.new_stream) restart();
            if (done) return;
            case (phase)
                WANT_CONTROL: begin
                    flags = it.in_byte;
                    fidx  = 3'd0;
                    phase = WANT_ITEM;
                end
                WANT_ITEM: begin
                    if (flags[fidx]) begin
                        ref_hi = it.in_byte;
                        phase  = WANT_REF_LOW;
                    end else begin
                        void'(emit(it.in_byte));
                        advance_flag();
                    end
                end
                default: begin
                    word   = {ref_hi, it.in_byte};
                    offset = word[15:4];
                    len    = int'(it.in_byte[3:0]) + 2;
                    phase  = WANT_ITEM;
                    if (offset == wp) begin
                        put(8'h00, 1'b0, ST_END_MARK);
                        done = 1'b1;
                    end else begin
                        // byte by byte so an overlapping copy sees its own output
                        for (int i = 0; i < len; i++) begin
                            rd = offset + 12'(i);
                            if (!emit(dict[rd])) break;
                        end
                        advance_flag();
                    end
                end
            endcase
            if (it.last_byte && !done) begin
                if (nstep > 0) step_out[nstep-1].status = ST_NO_END;
                else put(8'h00, 1'b0, ST_NO_END);
                done = 1'b1;
            end
            if (nstep > 0) step_out[nstep-1].run_last = 1'b1;
            for (int i = 0; i < nstep; i++) output_due.push_back(step_out[i]);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            if (errors < 40) begin
                $display("%0t ns: %s got %0h want %0h", $realtime, what, got, want);
            end
            errors++;
        endtask

        task check_output(t_out got);
            t_out want;
            if (output_due.size() == 0) begin
                report("result with nothing due, total_out", got.total_out, 32'd0);
                return;
            end
            want = output_due.pop_front();
            if (got.out_byte !== want.out_byte)
                report("out_byte", 32'(got.out_byte), 32'(want.out_byte));
            if (got.has_byte !== want.has_byte)
                report("has_byte", 32'(got.has_byte), 32'(want.has_byte));
            if (got.status !== want.status)
                report("status", 32'(got.status), 32'(want.status));
            if (got.run_last !== want.run_last)
                report("run_last", 32'(got.run_last), 32'(want.run_last));
            if (got.total_out !== want.total_out) report("total_out", got.total_out, want.total_out);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        o_in_ready;
    t_in         in_item;
    logic        o_out_valid;
    logic        out_ready;
    t_out        o_out;
    logic        cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] cfg_data;

    lzfu_board   sb;
    int          in_idle_pct;
    int          out_idle_pct;
    int          items_sent;
    int          cycle_count;
    logic [7:0]  ref_low_due;

    compressed_rtf_lz_decompressor i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("compressed_rtf_lz_decompressor: mismatch");
        $finish;
    end

    // every accepted transaction on each channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_valid && o_cfg_ready) sb.raw_size = cfg_data;
            if (in_valid && o_in_ready) sb.decode_byte(in_item);
            if (o_out_valid && out_ready) sb.check_output(o_out);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    task automatic send_item(t_in it);
        items_sent++;
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send(logic [7:0] b, logic fresh, logic fin);
        t_in it;
        it.in_byte    = b;
        it.new_stream = fresh;
        it.last_byte  = fin;
        send_item(it);
    endtask

    // sender holds off until every result due has come out
    task automatic drain(int extra);
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.output_due.size() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_raw_size(logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_raw_size();
        int pick;
        pick = $urandom_range(0, 5);
        case (pick)
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return 32'($urandom_range(0, 150));
            default: return $urandom;
        endcase
    endfunction

    // next byte of a well-formed stream, chosen from the decoder's current position
    function automatic logic [7:0] next_wellformed(bit first, bit want_end);
        logic [15:0] word;
        logic [11:0] off;
        int          pick;
        logic [7:0]  b;
        if (first || sb.phase == WANT_CONTROL) begin
            pick = $urandom_range(0, 7);
            b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
        end else if (sb.phase == WANT_REF_LOW) begin
            b = ref_low_due;
        end else if (!sb.flags[sb.fidx]) begin
            b = 8'($urandom);
        end else begin
            if (want_end) begin
                off = sb.wp;
            end else begin
                pick = $urandom_range(0, 3);
                case (pick)
                    0, 1:    off = sb.wp - 12'($urandom_range(1, 16));
                    2:       off = 12'($urandom_range(0, PRESET_LENGTH - 1));
                    default: off = 12'($urandom);
                endcase
                if (off == sb.wp) off = off + 12'd1;
            end
            word        = {off, 4'($urandom_range(0, 15))};
            b           = word[15:8];
            ref_low_due = word[7:0];
        end
        return b;
    endfunction

    task automatic run_stream();
        int   len;
        int   sent;
        int   style;
        t_in  it;
        len  = $urandom_range(4, 40);
        sent = 0;
        if ($urandom_range(0, 99) < 75) begin
            // 0: end marker, 1: last byte flag, 2: cut off by the next stream
            style = $urandom_range(0, 2);
            while (!(sent > 0 && sb.done) && sent < 200) begin
                it.new_stream = (sent == 0);
                it.in_byte    = next_wellformed(sent == 0, style == 0 && sent >= len);
                it.last_byte  = (style == 1 && sent >= len - 1);
                send_item(it);
                sent++;
                if (style == 2 && sent >= len) break;
            end
            repeat ($urandom_range(0, 2)) send(8'($urandom), 1'b0, 1'($urandom));
        end else begin
            for (int i = 0; i < len; i++) begin
                send(8'($urandom), i == 0 || $urandom_range(0, 19) == 0,
                     $urandom_range(0, 15) == 0);
            end
        end
    endtask

    initial begin
        int target;
        sb           = new();
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        out_ready    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = 32'd0;
        items_sent   = 0;
        ref_low_due  = 8'h00;
        in_idle_pct  = 20;
        out_idle_pct = 62;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_raw_size(32'hFFFF_FFFF);
        // literals at the byte extremes, a copy out of the preset text
        send(8'h02, 1'b1, 1'b0);
        send(8'hFF, 1'b0, 1'b0);
        send(8'h00, 1'b0, 1'b0);
        send(8'h0F, 1'b0, 1'b0);
        send(8'h00, 1'b0, 1'b0);
        send(8'h80, 1'b0, 1'b0);
        send(8'h7F, 1'b0, 1'b0);
        send(8'h55, 1'b0, 1'b0);
        send(8'hAA, 1'b0, 1'b0);
        send(8'h01, 1'b0, 1'b0);
        send(8'hFF, 1'b0, 1'b0);
        // overlapping copy repeats the last byte seventeen times
        send(8'({sb.wp - 12'd1, 4'hF} >> 8), 1'b0, 1'b0);
        send(8'({sb.wp - 12'd1, 4'hF}), 1'b0, 1'b0);
        // copy that wraps from the top of the dictionary to entry zero
        send(8'hFF, 1'b0, 1'b0);
        send(8'hF0, 1'b0, 1'b0);
        // end marker together with last byte, then a byte that is ignored
        send(8'({sb.wp, 4'h0} >> 8), 1'b0, 1'b0);
        send(8'({sb.wp, 4'h0}), 1'b0, 1'b1);
        send(8'h3C, 1'b0, 1'b1);

        drain(DRAIN_CYCLES);
        write_raw_size(32'd0);
        // overflow part way through the second copy
        send(8'hFF, 1'b1, 1'b0);
        send(8'h00, 1'b0, 1'b0);
        send(8'h0F, 1'b0, 1'b0);
        send(8'h06, 1'b0, 1'b0);
        send(8'h4F, 1'b0, 1'b0);
        // input ends without marker: once with no byte out, once on a literal
        send(8'h00, 1'b1, 1'b1);
        send(8'h00, 1'b1, 1'b0);
        send(8'hC3, 1'b0, 1'b1);

        for (int ph = 0; ph < 3; ph++) begin
            in_idle_pct  = (ph == 0) ? 20 : (ph == 1) ? 62 : 0;
            out_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 20 : 0;
            drain(DRAIN_CYCLES);
            write_raw_size(pick_raw_size());
            target = items_sent + 90;
            while (items_sent < target) begin
                if ($urandom_range(0, 3) == 0) begin
                    drain(DRAIN_CYCLES);
                    write_raw_size(pick_raw_size());
                end else if ($urandom_range(0, 9) == 0) begin
                    drain(0);
                end
                run_stream();
            end
        end

        drain(DRAIN_CYCLES);
        if (sb.errors == 0) begin
            $display("compressed_rtf_lz_decompressor: match");
        end else begin
            $display("compressed_rtf_lz_decompressor: mismatch");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/crlz_pkg.sv
hw/rtl/crlz_dict_ram.sv
hw/rtl/crlz_core.sv
hw/rtl/compressed_rtf_lz_decompressor.sv
sim/compressed_rtf_lz_decompressor_test.sv
